// ----- rtl/s2cd_pkg.sv -----
package s2cd_pkg;

    // datapath operation selected by one control word
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DAYQ,
        OP_DAYR,
        OP_HOUR,
        OP_MREST,
        OP_MIN,
        OP_SEC,
        OP_QUAD,
        OP_YEAR,
        OP_MONTH,
        OP_DONE
    } t_op;

    // how the step counter moves after a step
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_GT,
        JC_IN,
        JC_OUT
    } t_jc;

    typedef logic [3:0] t_pc;

    typedef struct packed {
        t_op        op;
        t_jc        jc;
        t_pc        target;
    } t_ctrl;

    typedef struct packed {
        logic in_beat;
        logic gt;
        logic out_free;
    } t_stat;

    localparam logic [16:0] SECONDS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECONDS_PER_MIN  = 6'd60;
    localparam logic [11:0] FIRST_YEAR       = 12'd2021;
    localparam logic [10:0] DAYS_PER_YEAR    = 11'd365;
    localparam logic [10:0] DAYS_PER_QUAD    = 11'd1461;
    localparam logic [2:0]  FIRST_WEEKDAY    = 3'd4;
    localparam logic [3:0]  MONTH_JAN        = 4'd1;
    localparam logic [3:0]  MONTH_FEB        = 4'd2;
    localparam logic [3:0]  MONTH_APR        = 4'd4;
    localparam logic [3:0]  MONTH_JUN        = 4'd6;
    localparam logic [3:0]  MONTH_SEP        = 4'd9;
    localparam logic [3:0]  MONTH_NOV        = 4'd11;

    // reciprocals, exact over the operand ranges used
    // days: (secs >> 7) / 675, hours: (rest >> 4) / 225,
    // minutes: (rest >> 2) / 15, weeks: days / 7
    localparam logic [24:0] RECIP_DAY  = 25'd25451659;
    localparam int          DAY_SHIFT  = 34;
    localparam logic [13:0] RECIP_HOUR = 14'd9321;
    localparam int          HOUR_SHIFT = 21;
    localparam logic [10:0] RECIP_MIN  = 11'd1093;
    localparam int          MIN_SHIFT  = 14;
    localparam logic [15:0] RECIP_WEEK = 16'd37450;
    localparam int          WEEK_SHIFT = 18;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            MONTH_FEB:                                  len = 5'd28 + {4'd0, leap};
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default:                                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/s2cd_seq.sv -----
module s2cd_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  s2cd_pkg::t_stat  i_stat,
    output s2cd_pkg::t_ctrl  o_ctrl
);
    import s2cd_pkg::*;

    localparam t_pc STEP_IDLE   = 4'd0;
    localparam t_pc STEP_DAYQ   = 4'd1;
    localparam t_pc STEP_DAYR   = 4'd2;
    localparam t_pc STEP_HOUR   = 4'd3;
    localparam t_pc STEP_MREST  = 4'd4;
    localparam t_pc STEP_MIN    = 4'd5;
    localparam t_pc STEP_SEC    = 4'd6;
    localparam t_pc STEP_QUAD   = 4'd7;
    localparam t_pc STEP_YEAR   = 4'd8;
    localparam t_pc STEP_MONTH  = 4'd9;
    localparam t_pc STEP_DONE   = 4'd10;

    // microprogram: op, jump kind, target
    function automatic t_ctrl rom_word(input t_pc addr);
        t_ctrl w;
        unique case (addr)
            STEP_IDLE:   w = '{OP_IDLE,   JC_IN,   STEP_IDLE};
            STEP_DAYQ:   w = '{OP_DAYQ,   JC_NEXT, STEP_IDLE};
            STEP_DAYR:   w = '{OP_DAYR,   JC_NEXT, STEP_IDLE};
            STEP_HOUR:   w = '{OP_HOUR,   JC_NEXT, STEP_IDLE};
            STEP_MREST:  w = '{OP_MREST,  JC_NEXT, STEP_IDLE};
            STEP_MIN:    w = '{OP_MIN,    JC_NEXT, STEP_IDLE};
            STEP_SEC:    w = '{OP_SEC,    JC_NEXT, STEP_IDLE};
            STEP_QUAD:   w = '{OP_QUAD,   JC_GT,   STEP_QUAD};
            STEP_YEAR:   w = '{OP_YEAR,   JC_GT,   STEP_YEAR};
            STEP_MONTH:  w = '{OP_MONTH,  JC_GT,   STEP_MONTH};
            STEP_DONE:   w = '{OP_DONE,   JC_OUT,  STEP_IDLE};
            default:     w = '{OP_IDLE,   JC_IN,   STEP_IDLE};
        endcase
        return w;
    endfunction

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w_ctrl;

    assign w_ctrl = rom_word(r_pc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        n_pc = r_pc;
        unique case (w_ctrl.jc)
            JC_NEXT: n_pc = r_pc + 4'd1;
            JC_GT:   n_pc = i_stat.gt ? w_ctrl.target : r_pc + 4'd1;
            JC_IN:   n_pc = i_stat.in_beat ? r_pc + 4'd1 : r_pc;
            JC_OUT:  n_pc = i_stat.out_free ? w_ctrl.target : r_pc;
            default: n_pc = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- rtl/seconds_to_calendar_date.sv -----
// Converts a count of seconds since 2021-01-01 00:00:00 into a Gregorian
// date and time of day: year, month, day, hour, minute, second, weekday
// (0 is Monday) and a leap-year flag. One input beat gives one output beat.
// A short microprogram in a constant table steps one shared datapath. Six
// fixed steps split the count with reciprocal multiplications by constants:
// whole days and seconds into the day, hour, seconds into the hour, minute
// and second, with the weekday taken from the day count mod 7 on the way.
// Then three walks strip four-year blocks, single years and months from the
// day number, one compare and subtract per cycle, each walk ending at its
// first failed compare. How long a conversion runs is set by the number of
// blocks, years and months walked. The input side takes a new beat in the
// cycle after the result is loaded; one result may wait downstream while the
// next conversion runs, and a result still waiting when the next one is
// done holds the sequencer in its last step.
module seconds_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // seconds_count[30:0], zero fill [31]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // year_value[11:0], month_value[15:12], day_value[20:16], hour_value[25:21],
    // minute_value[31:26], second_value[37:32], weekday_value[40:38],
    // leap_flag[41], zero fill [47:42]
    output logic [47:0] o_m_axis_tdata
);
    import s2cd_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    // datapath registers
    logic [30:0] r_secs,   n_secs;    // seconds count of the beat in progress
    logic [14:0] r_days,   n_days;    // whole days since the epoch
    logic [16:0] r_rest,   n_rest;    // seconds into the day
    logic [11:0] r_mrest,  n_mrest;   // seconds into the hour
    logic [2:0]  r_wday,   n_wday;
    logic [14:0] r_dnum,   n_dnum;    // 1-based day number
    logic [11:0] r_year,   n_year;
    logic [3:0]  r_month,  n_month;
    logic [4:0]  r_hour,   n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [47:0] r_out_data,  n_out_data;

    logic        w_in_beat;
    logic        w_out_free;
    logic [14:0] w_days;
    logic [16:0] w_day_secs;
    logic [16:0] w_rest;
    logic [2:0]  w_q7;
    logic [2:0]  w_wday0;
    logic [3:0]  w_wday4;
    logic [2:0]  w_wday;
    logic [4:0]  w_hour;
    logic [11:0] w_hour_secs;
    logic [11:0] w_mrest;
    logic [5:0]  w_minute;
    logic [5:0]  w_min_secs;
    logic [5:0]  w_second;
    logic        w_leap;
    logic [10:0] w_len;
    logic        w_gt;
    logic [14:0] w_dsub;

    s2cd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    assign o_s_axis_tready = (w_ctrl.op == OP_IDLE);
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // whole days: drop the factor 128 of 86400, then divide by 675
    assign w_days     = 15'(({25'd0, r_secs[30:7]} * {24'd0, RECIP_DAY}) >> DAY_SHIFT);
    // remainders fit their width, so the products only need the low bits
    assign w_day_secs = {2'd0, r_days} * SECONDS_PER_DAY;
    assign w_rest     = r_secs[16:0] - w_day_secs;

    // days mod 7: days - 7q equals days + q in the low three bits
    assign w_q7    = 3'(({6'd0, r_days} * {5'd0, RECIP_WEEK}) >> WEEK_SHIFT);
    assign w_wday0 = r_days[2:0] + w_q7;
    assign w_wday4 = {1'b0, w_wday0} + {1'b0, FIRST_WEEKDAY};
    assign w_wday  = (w_wday4 >= 4'd7) ? 3'(w_wday4 - 4'd7) : w_wday4[2:0];

    assign w_hour      = 5'(({14'd0, r_rest[16:4]} * {13'd0, RECIP_HOUR}) >> HOUR_SHIFT);
    assign w_hour_secs = {7'd0, r_hour} * SECONDS_PER_HOUR;
    assign w_mrest     = r_rest[11:0] - w_hour_secs;

    assign w_minute   = 6'(({11'd0, r_mrest[11:2]} * {10'd0, RECIP_MIN}) >> MIN_SHIFT);
    assign w_min_secs = r_minute * SECONDS_PER_MIN;
    assign w_second   = r_mrest[5:0] - w_min_secs;

    // years reached are 2021..2089, where divisible by 4 is the whole rule
    assign w_leap = (r_year[1:0] == 2'b00);

    // length of the block being stripped from the day number
    always_comb begin
        case (w_ctrl.op)
            OP_QUAD: w_len = DAYS_PER_QUAD;
            OP_YEAR: w_len = DAYS_PER_YEAR + {10'd0, w_leap};
            default: w_len = {6'd0, month_len(r_month, w_leap)};
        endcase
    end

    assign w_gt   = (r_dnum > {4'd0, w_len});
    assign w_dsub = r_dnum - {4'd0, w_len};

    assign w_stat.in_beat  = w_in_beat;
    assign w_stat.gt       = w_gt;
    assign w_stat.out_free = w_out_free;

    always_comb begin
        n_secs      = r_secs;
        n_days      = r_days;
        n_rest      = r_rest;
        n_mrest     = r_mrest;
        n_wday      = r_wday;
        n_dnum      = r_dnum;
        n_year      = r_year;
        n_month     = r_month;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;

        unique case (w_ctrl.op)
            OP_IDLE: begin
                if (w_in_beat) begin
                    n_secs = i_s_axis_tdata[30:0];
                end
            end
            OP_DAYQ: begin
                n_days = w_days;
            end
            OP_DAYR: begin
                n_rest = w_rest;
                n_dnum = r_days + 15'd1;
                n_wday = w_wday;
            end
            OP_HOUR: begin
                n_hour = w_hour;
            end
            OP_MREST: begin
                n_mrest = w_mrest;
            end
            OP_MIN: begin
                n_minute = w_minute;
            end
            OP_SEC: begin
                n_second = w_second;
                n_year   = FIRST_YEAR;
                n_month  = MONTH_JAN;
            end
            // every four-year block from 2021 holds one leap day, at its end
            OP_QUAD: begin
                if (w_gt) begin
                    n_dnum = w_dsub;
                    n_year = r_year + 12'd4;
                end
            end
            OP_YEAR: begin
                if (w_gt) begin
                    n_dnum = w_dsub;
                    n_year = r_year + 12'd1;
                end
            end
            OP_MONTH: begin
                if (w_gt) begin
                    n_dnum  = w_dsub;
                    n_month = r_month + 4'd1;
                end
            end
            OP_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, w_leap, r_wday, r_second, r_minute, r_hour,
                                   r_dnum[4:0], r_month, r_year};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_secs     <= n_secs;
        r_days     <= n_days;
        r_rest     <= n_rest;
        r_mrest    <= n_mrest;
        r_wday     <= n_wday;
        r_dnum     <= n_dnum;
        r_year     <= n_year;
        r_month    <= n_month;
        r_hour     <= n_hour;
        r_minute   <= n_minute;
        r_second   <= n_second;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/s2cd_chk.sv -----
module s2cd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);
    logic w_in_beat;
    logic w_stall;

    assign w_in_beat = i_s_axis_tvalid && o_s_axis_tready;
    assign w_stall   = o_m_axis_tvalid && !i_m_axis_tready;

    // result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    // one conversion at a time: busy right after taking a beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !o_s_axis_tready)
        else $error("input taken while a conversion runs");

    // leap flag agrees with the year
    a_leap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[41] == (o_m_axis_tdata[1:0] == 2'b00)))
        else $error("leap flag disagrees with year");

    // calendar fields in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:12] != 4'd0) && (o_m_axis_tdata[15:12] <= 4'd12)
            && (o_m_axis_tdata[20:16] != 5'd0) && (o_m_axis_tdata[25:21] <= 5'd23)
            && (o_m_axis_tdata[31:26] <= 6'd59) && (o_m_axis_tdata[37:32] <= 6'd59)
            && (o_m_axis_tdata[40:38] <= 3'd6))
        else $error("calendar field out of range");

endmodule

bind seconds_to_calendar_date s2cd_chk u_s2cd_chk (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import s2cd_pkg::*;

    localparam int unsigned SECS_IN_DAY  = 86400;
    localparam int unsigned SECS_IN_HOUR = 3600;
    localparam int unsigned EPOCH_YEAR   = 2021;
    localparam int unsigned EPOCH_WDAY   = 4;       // 2021-01-01 was a friday
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 150;     // a few conversions worth
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned HOLD_CYCLES  = 3000;

    // result fields from the highest bit down, as on o_m_axis_tdata
    typedef struct packed {
        logic        leap;
        logic [2:0]  weekday;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_cal_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;      // seconds_count[30:0], zero fill [31]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;           // year, month, day, hour, minute,
                                           // second, weekday, leap, zero fill

    logic [30:0] seconds_queue[$];         // stimulus not yet offered
    t_cal_date   expected_dates[$];        // predicted dates in beat order

    int unsigned date_errors = 0;
    int unsigned dates_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    t_cal_date   got_date;
    t_cal_date   want_date;

    seconds_to_calendar_date uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // gregorian rule: every fourth year, except centuries not divisible by 400
    function automatic bit is_leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mo, input bit lp);
        int unsigned n;
        case (mo)
            MONTH_FEB:                                  n = 28 + lp;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 30;
            default:                                    n = 31;
        endcase
        return n;
    endfunction

    // days from the epoch to the first of the given month
    function automatic int unsigned month_start_day(input int unsigned yr, input int unsigned mo);
        int unsigned d;
        int unsigned y;
        int unsigned m;
        d = 0;
        for (y = EPOCH_YEAR; y < yr; y++)
            d += 365 + is_leap_year(y);
        for (m = 1; m < mo; m++)
            d += days_in_month(m, is_leap_year(yr));
        return d;
    endfunction

    // calendar date of a second count: strip whole years, then whole months
    function automatic t_cal_date seconds_to_date(input logic [30:0] secs);
        t_cal_date   r;
        int unsigned days;
        int unsigned rest;
        int unsigned dnum;
        int unsigned yr;
        int unsigned mo;
        bit          lp;
        days = secs / SECS_IN_DAY;
        rest = secs % SECS_IN_DAY;
        dnum = days + 1;
        yr   = EPOCH_YEAR;
        while (dnum > 365 + is_leap_year(yr)) begin
            dnum -= 365 + is_leap_year(yr);
            yr++;
        end
        lp = is_leap_year(yr);
        mo = 1;
        while (mo < 12 && dnum > days_in_month(mo, lp)) begin
            dnum -= days_in_month(mo, lp);
            mo++;
        end
        r.year    = yr[11:0];
        r.month   = mo[3:0];
        r.day     = dnum[4:0];
        r.hour    = 5'(rest / SECS_IN_HOUR);
        r.minute  = 6'((rest % SECS_IN_HOUR) / 60);
        r.second  = 6'(rest % 60);
        r.weekday = 3'((days + EPOCH_WDAY) % 7);
        r.leap    = lp;
        return r;
    endfunction

    function automatic string date_text(input t_cal_date d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd %0d lp %0d",
                         d.year, d.month, d.day, d.hour, d.minute, d.second,
                         d.weekday, d.leap);
    endfunction

    task automatic note_mismatch(input string what, input t_cal_date want, input t_cal_date got);
        date_errors++;
        if (date_errors <= REPORT_MAX)
            $display("[%0t] %s: expected %s, got %s",
                     $time, what, date_text(want), date_text(got));
    endtask

    // stimulus: directed corners first, then mostly calendar-shaped random values
    initial begin
        int unsigned yr;
        int unsigned mo;
        int unsigned base;
        int unsigned n;
        logic [30:0] v;

        // time-of-day rollovers and the first week, one beat per weekday
        seconds_queue.push_back(31'd0);
        seconds_queue.push_back(31'd1);
        seconds_queue.push_back(31'd59);
        seconds_queue.push_back(31'd60);
        seconds_queue.push_back(31'd3599);
        seconds_queue.push_back(31'd3600);
        seconds_queue.push_back(31'd86399);
        for (n = 1; n < 7; n++)
            seconds_queue.push_back(31'(n * SECS_IN_DAY + n * 4000));
        // end of the first non-leap february and year turnover
        seconds_queue.push_back(31'(month_start_day(2021, 3) * SECS_IN_DAY - 1));
        seconds_queue.push_back(31'(month_start_day(2022, 1) * SECS_IN_DAY - 1));
        seconds_queue.push_back(31'(month_start_day(2022, 1) * SECS_IN_DAY));
        // leap day and the day after it, early and late in the range
        seconds_queue.push_back(31'(month_start_day(2024, 3) * SECS_IN_DAY - 1));
        seconds_queue.push_back(31'(month_start_day(2024, 3) * SECS_IN_DAY));
        seconds_queue.push_back(31'(month_start_day(2025, 1) * SECS_IN_DAY - 1));
        seconds_queue.push_back(31'(month_start_day(2088, 3) * SECS_IN_DAY - 1));
        seconds_queue.push_back(31'(month_start_day(2089, 1) * SECS_IN_DAY - 1));
        seconds_queue.push_back(31'(month_start_day(2089, 1) * SECS_IN_DAY));
        // single top bit, alternating bits, and the largest count
        seconds_queue.push_back(31'h4000_0000);
        seconds_queue.push_back(31'h5555_5555);
        seconds_queue.push_back(31'h2aaa_aaaa);
        seconds_queue.push_back(31'h7fff_ffff);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: v = 31'($urandom);
                3: v = 31'($urandom_range(0, 20 * SECS_IN_DAY));
                4: v = 31'($urandom_range(2147483647 - 40 * SECS_IN_DAY, 2147483647));
                default: begin
                    // around a month boundary in a random year
                    yr   = $urandom_range(EPOCH_YEAR, 2088);
                    mo   = $urandom_range(1, 12);
                    base = month_start_day(yr, mo) * SECS_IN_DAY;
                    if (base == 0)
                        base = SECS_IN_DAY;
                    case ($urandom_range(0, 3))
                        0: v = 31'(base);
                        1: v = 31'(base - 1);
                        2: v = 31'(base - SECS_IN_DAY + $urandom_range(0, SECS_IN_DAY - 1));
                        default: v = 31'(base + $urandom_range(0, SECS_IN_DAY - 1));
                    endcase
                end
            endcase
            seconds_queue.push_back(v);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the stimulus to be taken, then for every date to come back
        while (seconds_queue.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        while (expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (date_errors == 0 && expected_dates.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // driver: bursts of beats with random gaps, some stretches gap-free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_dates.push_back(seconds_to_date(i_s_axis_tdata[30:0]));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (seconds_queue.size() != 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {1'b0, seconds_queue.pop_front()};
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 80);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat and drives the receiver's stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_date = o_m_axis_tdata[41:0];
                if (expected_dates.size() == 0) begin
                    note_mismatch("unexpected beat", '0, got_date);
                end else begin
                    want_date = expected_dates.pop_front();
                    if (got_date !== want_date)
                        note_mismatch("wrong date", want_date, got_date);
                end
                dates_seen++;
                // long hold-off so the block backs up and stalls its input
                if (dates_seen == 150 || dates_seen == 1100)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                case ((cycle_count / 400) % 4)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= $urandom_range(0, 1);
                    2: i_m_axis_tready <= (cycle_count % 7) < 3;
                    default: i_m_axis_tready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
rtl/s2cd_pkg.sv
rtl/s2cd_seq.sv
rtl/seconds_to_calendar_date.sv
rtl/s2cd_chk.sv
bench/testbench.sv
